@@ rtl/arqshc_pkg.sv @@
`default_nettype none

package arqshc_pkg;

    typedef enum logic [2:0] {
        CMD_FORCE_OFF     = 3'd0,
        CMD_START_INIT    = 3'd1,
        CMD_PEER_HS       = 3'd2,
        CMD_POLL_TIMEOUT  = 3'd3,
        CMD_TX_ACTIVITY   = 3'd4,
        CMD_RX_ACTIVITY   = 3'd5,
        CMD_HS_EMITTED    = 3'd6
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_OFF  = 3'b001,
        MODE_INIT = 3'b010,
        MODE_ON   = 3'b100
    } mode_t;

    localparam logic [1:0] SESS_OFF  = 2'd0;
    localparam logic [1:0] SESS_INIT = 2'd1;
    localparam logic [1:0] SESS_ON   = 2'd2;

    localparam logic [31:0] TIMEOUT_RESET = 32'd20000;
    localparam logic        REG_TIMEOUT   = 1'b0;

    typedef struct packed {
        logic [1:0]  session_state;
        logic [31:0] session_id;
        logic        handshake_pending;
        logic        session_restarted;
        logic        rings_wipe;
        logic        timed_out;
    } result_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] code;
        code = SESS_OFF;
        unique case (m)
            MODE_OFF:  code = SESS_OFF;
            MODE_INIT: code = SESS_INIT;
            MODE_ON:   code = SESS_ON;
            default:   code = SESS_OFF;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

@@ rtl/arqshc_session.sv @@
`default_nettype none

module arqshc_session
    import arqshc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        step,
    input  wire logic [2:0]  command,
    input  wire logic [1:0]  peer_mode,
    input  wire logic [31:0] peer_identifier,
    input  wire logic [31:0] time_now,
    input  wire logic [31:0] idle_limit,
    output result_t          result
);

    mode_t       mode_reg,  mode_next;
    logic [31:0] ident_reg, ident_next;
    logic        flag_reg,  flag_next;
    logic [31:0] tx_reg,    tx_next;
    logic [31:0] rx_reg,    rx_next;
    logic        restarted;
    logic        wipe;
    logic        tmo;
    logic        match;
    logic [31:0] dtx;
    logic [31:0] drx;

    assign match = (peer_identifier == ident_reg);
    assign dtx   = time_now - tx_reg;
    assign drx   = time_now - rx_reg;

    always_comb
    begin
        mode_next  = mode_reg;
        ident_next = ident_reg;
        flag_next  = flag_reg;
        tx_next    = tx_reg;
        rx_next    = rx_reg;
        restarted  = 1'b0;
        wipe       = 1'b0;
        tmo        = 1'b0;
        unique case (command)
            CMD_FORCE_OFF:
            begin
                mode_next  = MODE_OFF;
                ident_next = '0;
                flag_next  = 1'b0;
                tx_next    = '0;
                rx_next    = '0;
                wipe       = 1'b1;
            end
            CMD_START_INIT:
            begin
                mode_next  = MODE_INIT;
                ident_next = time_now;
                flag_next  = 1'b0;
                tx_next    = time_now;
                rx_next    = time_now;
                wipe       = 1'b1;
            end
            CMD_PEER_HS:
            begin
                priority if (mode_reg == MODE_ON && match)
                begin
                    flag_next = (peer_mode == SESS_INIT);
                end
                else if (mode_reg == MODE_INIT && match)
                begin
                    mode_next = MODE_ON;
                    flag_next = 1'b0;
                    restarted = 1'b1;
                end
                else if (mode_reg != MODE_INIT || peer_identifier > ident_reg)
                begin
                    mode_next  = MODE_ON;
                    ident_next = peer_identifier;
                    flag_next  = 1'b1;
                    tx_next    = time_now;
                    rx_next    = time_now;
                    restarted  = 1'b1;
                    wipe       = 1'b1;
                end
                else
                begin
                end
            end
            CMD_POLL_TIMEOUT:
            begin
                if (mode_reg != MODE_OFF && (dtx > idle_limit || drx > idle_limit))
                begin
                    mode_next  = MODE_OFF;
                    ident_next = '0;
                    flag_next  = 1'b0;
                    tx_next    = '0;
                    rx_next    = '0;
                    wipe       = 1'b1;
                    tmo        = 1'b1;
                end
            end
            CMD_TX_ACTIVITY:
            begin
                tx_next = time_now;
            end
            CMD_RX_ACTIVITY:
            begin
                rx_next = time_now;
            end
            CMD_HS_EMITTED:
            begin
                flag_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        result.session_state     = mode_code(mode_next);
        result.session_id        = ident_next;
        result.handshake_pending = flag_next;
        result.session_restarted = restarted;
        result.rings_wipe        = wipe;
        result.timed_out         = tmo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_OFF;
            ident_reg <= '0;
            flag_reg  <= 1'b0;
            tx_reg    <= '0;
            rx_reg    <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            ident_reg <= ident_next;
            flag_reg  <= flag_next;
            tx_reg    <= tx_next;
            rx_reg    <= rx_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/arq_session_handshake_control.sv @@
// Channel   Handshake                 Payload
// cmd       cmd_valid / cmd_stall     command, peer_mode, peer_identifier, time_now
// res       res_valid / res_stall     session_state, session_id, handshake_pending,
//                                     session_restarted, rings_wipe, timed_out
// cfg       APB write/read            session_timeout_ms at byte address 0
//
// One beat per cycle sustained while res_stall is low; each command beat passes
// through the input register, then the session update into the result register.
// Session state updates as each beat leaves the input register, so beats chain
// back to back. Reset sets the session off and the timeout to 20000 ms.
// A stalled result holds; the input register still takes a beat while empty.
`default_nettype none

module arq_session_handshake_control
    import arqshc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cmd_valid,
    output logic             cmd_stall,
    input  wire logic [2:0]  command,
    input  wire logic [1:0]  peer_mode,
    input  wire logic [31:0] peer_identifier,
    input  wire logic [31:0] time_now,

    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [1:0]       session_state,
    output logic [31:0]      session_id,
    output logic             handshake_pending,
    output logic             session_restarted,
    output logic             rings_wipe,
    output logic             timed_out,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic        in_valid_reg;
    logic [2:0]  command_reg;
    logic [1:0]  peer_mode_reg;
    logic [31:0] peer_id_reg;
    logic [31:0] time_reg;
    logic        out_valid_reg;
    result_t     out_reg;
    result_t     result;
    logic [31:0] timeout_reg;
    logic        out_free;
    logic        advance;
    logic        take;

    assign out_free  = !out_valid_reg || !res_stall;
    assign advance   = in_valid_reg && out_free;
    assign take      = cmd_valid && !cmd_stall;
    assign cmd_stall = in_valid_reg && !out_free;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TIMEOUT) ? timeout_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (psel && penable && pwrite && paddr[2] == REG_TIMEOUT)
        begin
            timeout_reg <= pwdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            command_reg   <= command;
            peer_mode_reg <= peer_mode;
            peer_id_reg   <= peer_identifier;
            time_reg      <= time_now;
        end
    end

    arqshc_session u_session (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (advance),
        .command         (command_reg),
        .peer_mode       (peer_mode_reg),
        .peer_identifier (peer_id_reg),
        .time_now        (time_reg),
        .idle_limit      (timeout_reg),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign res_valid         = out_valid_reg;
    assign session_state     = out_reg.session_state;
    assign session_id        = out_reg.session_id;
    assign handshake_pending = out_reg.handshake_pending;
    assign session_restarted = out_reg.session_restarted;
    assign rings_wipe        = out_reg.rings_wipe;
    assign timed_out         = out_reg.timed_out;

endmodule

`default_nettype wire

@@ bench/tb_arq_session_handshake_control.sv @@
`timescale 1ns / 100ps

module tb_arq_session_handshake_control;
    import arqshc_pkg::*;

    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam logic [2:0] TIMEOUT_ADDR = {REG_TIMEOUT, 2'b00};
    localparam logic [2:0] CMD_UNUSED = 3'd7;
    localparam logic [1:0] PEER_UNDEFINED = 2'd3;

    class session_scoreboard;
        logic [1:0]  mode;
        logic [31:0] ident;
        logic        flag;
        logic [31:0] tx_stamp;
        logic [31:0] rx_stamp;
        logic [31:0] timeout;
        result_t     expected_reports[$];
        int          errors;
        int          reported;

        function void clear_session();
            mode = SESS_OFF;
            ident = '0;
            flag = 1'b0;
            tx_stamp = '0;
            rx_stamp = '0;
        endfunction

        function void power_on();
            clear_session();
            timeout = TIMEOUT_RESET;
            expected_reports.delete();
            errors = 0;
            reported = 0;
        endfunction

        function void set_timeout(logic [31:0] value);
            timeout = value;
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen)
            begin
                errors++;
                if (reported < 10)
                begin
                    $display("mismatch %0s: expected %h, got %h", name, want, seen);
                    reported++;
                end
            end
        endfunction

        function void note_command(logic [2:0] cmd, logic [1:0] peer, logic [31:0] pid,
                                   logic [31:0] now);
            result_t     r;
            logic        restart;
            logic        wipe;
            logic        tmo;
            logic [31:0] dtx;
            logic [31:0] drx;
            restart = 1'b0;
            wipe = 1'b0;
            tmo = 1'b0;
            case (cmd)
                CMD_FORCE_OFF:
                begin
                    clear_session();
                    wipe = 1'b1;
                end
                CMD_START_INIT:
                begin
                    mode = SESS_INIT;
                    ident = now;
                    tx_stamp = now;
                    rx_stamp = now;
                    flag = 1'b0;
                    wipe = 1'b1;
                end
                CMD_PEER_HS:
                begin
                    if (mode == SESS_ON && pid == ident)
                        flag = (peer == SESS_INIT);
                    else if (mode == SESS_INIT && pid == ident)
                    begin
                        mode = SESS_ON;
                        flag = 1'b0;
                        restart = 1'b1;
                    end
                    else if (mode == SESS_INIT && pid < ident)
                        flag = flag;
                    else
                    begin
                        // join the peer's session
                        mode = SESS_ON;
                        ident = pid;
                        tx_stamp = now;
                        rx_stamp = now;
                        flag = 1'b1;
                        restart = 1'b1;
                        wipe = 1'b1;
                    end
                end
                CMD_POLL_TIMEOUT:
                begin
                    dtx = now - tx_stamp;
                    drx = now - rx_stamp;
                    if (mode != SESS_OFF && (dtx > timeout || drx > timeout))
                    begin
                        clear_session();
                        wipe = 1'b1;
                        tmo = 1'b1;
                    end
                end
                CMD_TX_ACTIVITY:
                    tx_stamp = now;
                CMD_RX_ACTIVITY:
                    rx_stamp = now;
                CMD_HS_EMITTED:
                    flag = 1'b0;
                default:
                    ;
            endcase
            r.session_state = mode;
            r.session_id = ident;
            r.handshake_pending = flag;
            r.session_restarted = restart;
            r.rings_wipe = wipe;
            r.timed_out = tmo;
            expected_reports.push_back(r);
        endfunction

        function void check_report(result_t got);
            result_t want;
            if (expected_reports.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    $display("mismatch: result beat with nothing expected");
                    reported++;
                end
                return;
            end
            want = expected_reports.pop_front();
            compare_field("session_state", 32'(want.session_state),
                          32'(got.session_state));
            compare_field("session_id", want.session_id, got.session_id);
            compare_field("handshake_pending", 32'(want.handshake_pending),
                          32'(got.handshake_pending));
            compare_field("session_restarted", 32'(want.session_restarted),
                          32'(got.session_restarted));
            compare_field("rings_wipe", 32'(want.rings_wipe), 32'(got.rings_wipe));
            compare_field("timed_out", 32'(want.timed_out), 32'(got.timed_out));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_stall;
    logic [2:0]  command;
    logic [1:0]  peer_mode;
    logic [31:0] peer_identifier;
    logic [31:0] time_now;
    logic        res_valid;
    logic        res_stall;
    logic [1:0]  session_state;
    logic [31:0] session_id;
    logic        handshake_pending;
    logic        session_restarted;
    logic        rings_wipe;
    logic        timed_out;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    session_scoreboard sb;
    result_t           res_beat;
    int                send_idle;
    int                recv_idle;
    int                hold_left;
    int                quiet_cycles;
    logic [31:0]       sim_ms;
    logic [31:0]       timeouts [7];

    arq_session_handshake_control dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd_valid         (cmd_valid),
        .cmd_stall         (cmd_stall),
        .command           (command),
        .peer_mode         (peer_mode),
        .peer_identifier   (peer_identifier),
        .time_now          (time_now),
        .res_valid         (res_valid),
        .res_stall         (res_stall),
        .session_state     (session_state),
        .session_id        (session_id),
        .handshake_pending (handshake_pending),
        .session_restarted (session_restarted),
        .rings_wipe        (rings_wipe),
        .timed_out         (timed_out),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            res_beat.session_state = session_state;
            res_beat.session_id = session_id;
            res_beat.handshake_pending = handshake_pending;
            res_beat.session_restarted = session_restarted;
            res_beat.rings_wipe = rings_wipe;
            res_beat.timed_out = timed_out;
            sb.check_report(res_beat);
        end
        if (hold_left > 0)
        begin
            res_stall <= 1'b1;
            hold_left--;
        end
        else
            res_stall <= ($urandom_range(0, 99) < recv_idle);
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_beat(input logic [2:0] cmd, input logic [1:0] peer,
                             input logic [31:0] pid, input logic [31:0] now);
        while ($urandom_range(0, 99) < send_idle)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        command <= cmd;
        peer_mode <= peer;
        peer_identifier <= pid;
        time_now <= now;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        sb.note_command(cmd, peer, pid, now);
    endtask

    task automatic wait_results_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (sb.expected_reports.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_timeout(input logic [31:0] value);
        logic [31:0] readback;
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= TIMEOUT_ADDR;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_timeout(value);
        pwrite <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        readback = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        sb.compare_field("timeout readback", value, readback);
    endtask

    task automatic send_random(input int count);
        logic [2:0]  cmd;
        logic [1:0]  peer;
        logic [31:0] pid;
        logic [31:0] now;
        logic [31:0] span;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            span = (sb.timeout < 32'd4000) ? (sb.timeout >> 1) + 32'd2 : 32'd2000;
            sim_ms = sim_ms + $urandom_range(0, span);
            now = sim_ms;
            pick = $urandom_range(0, 99);
            if (pick < 12)
            begin
                cmd = 3'($urandom_range(0, 7));
                peer = 2'($urandom_range(0, 3));
                pid = $urandom;
                now = $urandom;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (sb.mode == SESS_OFF && pick < 50)
                    cmd = (pick < 30) ? CMD_START_INIT : CMD_PEER_HS;
                else if (pick < 10)
                    cmd = CMD_START_INIT;
                else if (pick < 35)
                    cmd = CMD_PEER_HS;
                else if (pick < 57)
                    cmd = CMD_POLL_TIMEOUT;
                else if (pick < 70)
                    cmd = CMD_TX_ACTIVITY;
                else if (pick < 83)
                    cmd = CMD_RX_ACTIVITY;
                else if (pick < 92)
                    cmd = CMD_HS_EMITTED;
                else if (pick < 97)
                    cmd = CMD_FORCE_OFF;
                else
                    cmd = CMD_UNUSED;

                pick = $urandom_range(0, 9);
                if (pick < 4)
                    peer = SESS_ON;
                else if (pick < 7)
                    peer = SESS_INIT;
                else if (pick < 9)
                    peer = SESS_OFF;
                else
                    peer = PEER_UNDEFINED;

                pick = $urandom_range(0, 99);
                if (pick < 35)
                    pid = sb.ident;
                else if (pick < 50)
                    pid = sb.ident + 32'd1;
                else if (pick < 65)
                    pid = sb.ident - 32'd1;
                else if (pick < 70)
                    pid = '0;
                else if (pick < 75)
                    pid = '1;
                else
                    pid = $urandom;

                if (cmd == CMD_POLL_TIMEOUT)
                begin
                    pick = $urandom_range(0, 9);
                    // land one below, on, or one past the idle limit
                    if (pick < 4)
                    begin
                        now = ($urandom_range(0, 1) ? sb.tx_stamp : sb.rx_stamp)
                              + sb.timeout + $urandom_range(0, 2) - 32'd1;
                        sim_ms = now;
                    end
                    else if (pick < 5)
                        now = $urandom;
                end
            end
            send_beat(cmd, peer, pid, now);
        end
    endtask

    initial
    begin
        sb = new();
        sb.power_on();
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        command = CMD_FORCE_OFF;
        peer_mode = SESS_OFF;
        peer_identifier = '0;
        time_now = '0;
        res_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = TIMEOUT_ADDR;
        pwdata = '0;
        send_idle = 29;
        recv_idle = 69;
        hold_left = 0;
        quiet_cycles = 0;
        sim_ms = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_beat(CMD_POLL_TIMEOUT, SESS_OFF, 32'h0, 32'd0);
        send_beat(CMD_PEER_HS, SESS_ON, 32'hFFFF_FFFF, 32'd5);
        send_beat(CMD_PEER_HS, SESS_INIT, 32'hFFFF_FFFF, 32'd6);
        send_beat(CMD_PEER_HS, PEER_UNDEFINED, 32'hFFFF_FFFF, 32'd7);
        send_beat(CMD_PEER_HS, SESS_INIT, 32'hFFFF_FFFF, 32'd8);
        send_beat(CMD_HS_EMITTED, SESS_OFF, 32'h0, 32'd9);
        send_beat(CMD_PEER_HS, SESS_OFF, 32'h0, 32'd10);
        send_beat(CMD_TX_ACTIVITY, SESS_OFF, 32'h0, 32'd100);
        send_beat(CMD_RX_ACTIVITY, SESS_OFF, 32'h0, 32'd200);
        send_beat(CMD_POLL_TIMEOUT, SESS_OFF, 32'h0, 32'd20100);
        send_beat(CMD_POLL_TIMEOUT, SESS_OFF, 32'h0, 32'd20101);
        send_beat(CMD_START_INIT, SESS_OFF, 32'h0, 32'hFFFF_FFF0);
        send_beat(CMD_PEER_HS, SESS_ON, 32'd5, 32'hFFFF_FFF1);
        send_beat(CMD_PEER_HS, SESS_INIT, 32'hFFFF_FFF0, 32'hFFFF_FFF2);
        send_beat(CMD_FORCE_OFF, SESS_OFF, 32'h0, 32'hFFFF_FFF3);
        send_beat(CMD_START_INIT, SESS_OFF, 32'h0, 32'd1000);
        send_beat(CMD_PEER_HS, SESS_ON, 32'd1001, 32'd1001);
        send_beat(CMD_START_INIT, SESS_OFF, 32'h0, 32'd50);
        send_beat(CMD_POLL_TIMEOUT, SESS_OFF, 32'h0, 32'd20);
        send_beat(CMD_UNUSED, PEER_UNDEFINED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_beat(CMD_TX_ACTIVITY, SESS_OFF, 32'h0, 32'hFFFF_FFFF);
        send_beat(CMD_START_INIT, SESS_OFF, 32'h0, 32'd0);
        send_beat(CMD_RX_ACTIVITY, SESS_OFF, 32'h0, 32'd30000);
        send_beat(CMD_POLL_TIMEOUT, SESS_OFF, 32'h0, 32'd30000);
        wait_results_drained();

        timeouts[0] = '0;
        timeouts[1] = $urandom_range(20, 3000);
        timeouts[2] = 32'hFFFF_FFFF;
        timeouts[3] = $urandom_range(100, 800);
        timeouts[4] = TIMEOUT_RESET;
        timeouts[5] = $urandom;
        timeouts[6] = 32'd1;
        sim_ms = $urandom;

        for (int seg = 0; seg < 7; seg++)
        begin
            if (seg == 2)
            begin
                send_idle = 69;
                recv_idle = 29;
            end
            else if (seg == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_timeout(timeouts[seg]);
            if (seg == 1)
            begin
                send_random(40);
                hold_left = HOLD_OFF_CYCLES;
                send_random(75);
            end
            else if (seg == 3)
            begin
                send_random(50);
                wait_results_drained();
                send_random(65);
            end
            else
                send_random(115);
            wait_results_drained();
        end

        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
